// File: sv/npc_pkg.sv
// Shared types and constants for the nearest palette color classifier.
package npc_pkg;

  // Field widths.
  localparam int CHAN_W      = 16;
  localparam int ENTRY_W     = 4 * CHAN_W;
  localparam int ENTRY_IDX_W = 4;
  localparam int COUNT_W     = 5;
  localparam int IDX_OUT_W   = 4;
  localparam int SQ_W        = 2 * CHAN_W;
  localparam int DIST_W      = 34;

  // Stream packing.
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  // Item kinds carried on in_tuser.
  localparam logic KIND_STORE    = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } npc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               store;
    logic               start;
    logic               issue;
    logic [COUNT_W-1:0] issue_idx;
    logic               load_out;
  } npc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
  } npc_sts_t;

endpackage

// File: sv/npc_dpath.sv
// Datapath: palette memory, distance pipeline, best-match tracking and result register.
module npc_dpath
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  npc_cmd_t               cmd,
  output npc_sts_t               sts,
  input  logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [CHAN_W-1:0]      in_red,
  input  logic [CHAN_W-1:0]      in_green,
  input  logic [CHAN_W-1:0]      in_blue,
  input  logic [CHAN_W-1:0]      in_clear,
  output logic [IDX_OUT_W-1:0]   out_nearest_index,
  output logic [DIST_W-1:0]      out_distance
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [ENTRY_W-1:0]       mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] vld_r;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;

  logic [ENTRY_W-1:0]       sample_r;

  logic                     s1_v_r;
  logic [COUNT_W-1:0]       s1_idx_r;
  logic [ENTRY_W-1:0]       s1_data_r;
  logic                     s1_hit_r;
  logic [ENTRY_W-1:0]       s1_entry;

  logic                     s2_v_r;
  logic [COUNT_W-1:0]       s2_idx_r;
  logic [SQ_W-1:0]          s2_sq_r  [4];
  logic [SQ_W-1:0]          s2_sq_nxt[4];

  logic                     s3_v_r;
  logic [COUNT_W-1:0]       s3_idx_r;
  logic [DIST_W-1:0]        s3_sum_r;

  logic [COUNT_W-1:0]       best_idx_r;
  logic [DIST_W-1:0]        best_d_r;

  logic [IDX_OUT_W-1:0]     out_idx_r;
  logic [DIST_W-1:0]        out_dist_r;

  assign wr_addr = AW'(in_entry_index);
  assign rd_addr = AW'(cmd.issue_idx);
  assign wr_en   = cmd.store && (int'(in_entry_index) < PALETTE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_clear, in_blue, in_green, in_red};
    end
    if (cmd.issue) begin
      s1_data_r <= mem[rd_addr];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sample_r <= {in_clear, in_blue, in_green, in_red};
    end
    if (cmd.issue) begin
      s1_idx_r <= cmd.issue_idx;
      s1_hit_r <= vld_r[rd_addr];
    end
  end

  assign s1_entry = s1_hit_r ? s1_data_r : '0;

  always_comb begin
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] d;
    for (int k = 0; k < 4; k++) begin
      a = sample_r[k*CHAN_W +: CHAN_W];
      b = s1_entry[k*CHAN_W +: CHAN_W];
      d = (a >= b) ? (a - b) : (b - a);
      s2_sq_nxt[k] = SQ_W'(d) * SQ_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    s2_idx_r <= s1_idx_r;
    for (int k = 0; k < 4; k++) begin
      s2_sq_r[k] <= s2_sq_nxt[k];
    end
    s3_idx_r <= s2_idx_r;
    s3_sum_r <= DIST_W'(s2_sq_r[0]) + DIST_W'(s2_sq_r[1])
              + DIST_W'(s2_sq_r[2]) + DIST_W'(s2_sq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Entry zero seeds the search; later entries win only when strictly closer.
  always_ff @(posedge clk) begin
    if (s3_v_r && ((s3_idx_r == '0) || (s3_sum_r < best_d_r))) begin
      best_idx_r <= s3_idx_r;
      best_d_r   <= s3_sum_r;
    end
    if (cmd.load_out) begin
      out_idx_r  <= best_idx_r[IDX_OUT_W-1:0];
      out_dist_r <= best_d_r;
    end
  end

  assign sts.busy          = s1_v_r || s2_v_r || s3_v_r;
  assign out_nearest_index = out_idx_r;
  assign out_distance      = out_dist_r;

  a_s3_follows_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> $past(s2_v_r))
    else $error("distance stage valid without a preceding square stage");

  a_no_issue_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> !cmd.issue && !sts.busy)
    else $error("palette write while a scan is in flight");

endmodule

// File: sv/npc_ctrl.sv
// Controller: handshakes, color count register and the scan sequencer.
module npc_ctrl
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_kind,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  output npc_cmd_t           cmd,
  input  npc_sts_t           sts
);

  npc_state_t         state_r, state_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] scan_r, scan_nxt;
  logic [COUNT_W-1:0] last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] lim;
  logic               accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      scan_r      <= scan_nxt;
      last_r      <= last_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
    end
  end

  // Entries scanned: the count saturated at the depth, and never fewer than one.
  always_comb begin
    if (int'(count_r) > PALETTE_DEPTH) begin
      lim = COUNT_W'(PALETTE_DEPTH);
    end else begin
      lim = count_r;
    end
    if (lim == '0) begin
      lim = COUNT_W'(1);
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.issue_idx = scan_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_CLASSIFY) begin
            cmd.start = 1'b1;
            scan_nxt  = '0;
            last_nxt  = lim - COUNT_W'(1);
            state_nxt = ST_SCAN;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (scan_r == last_r) begin
          state_nxt = ST_FINISH;
        end else begin
          scan_nxt = scan_r + COUNT_W'(1);
        end
      end
      ST_FINISH: begin
        if (!sts.busy && (!out_valid_r || out_tready)) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> scan_r <= last_r && int'(scan_r) < PALETTE_DEPTH)
    else $error("scan address beyond the active palette");

  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.busy)
    else $error("result loaded while the distance pipeline is busy");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result presented without a completed scan");

endmodule

// File: sv/nearest_palette_color.sv
// Top level of the nearest palette color classifier.
//
// The in_ stream carries one transaction per item. in_tuser is the kind: a store
// transaction writes palette entry entry_index with the four channels, a classify
// transaction compares the sample against entries 0 to count-1 and returns one
// out_ transaction with the index of the first closest entry and its squared
// Euclidean distance. Stores produce no result.
// A classify transaction occupies the block until its result is registered; it
// scans n entries, n being the active entry count (color_count saturated at the
// depth, at least one). The single palette read port delivers one entry per
// cycle into a three-stage square, sum and compare pipeline that must drain
// before the result is registered.
// Reset clears the palette to zero through per-entry valid bits and sets
// color_count to 16. If the receiver stalls, the result waits in the output
// register while the next item is still accepted; a classify then holds at its
// end until the register is free. cfg_ writes are for idle periods only.
module nearest_palette_color
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata, lowest bit up: entry_index[3:0], red[19:4], green[35:20],
  // blue[51:36], clear[67:52], zero padding[71:68].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: kind (0 store, 1 classify).
  input  logic                   in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata, lowest bit up: nearest_index[3:0], distance[37:4],
  // zero padding[39:38].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Color count register.
  input  logic                   cfg_wr_en,
  input  logic [COUNT_W-1:0]     cfg_wr_data
);

  npc_cmd_t               cmd;
  npc_sts_t               sts;
  logic [IDX_OUT_W-1:0]   nearest_index;
  logic [DIST_W-1:0]      distance;

  npc_ctrl #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .sts        (sts)
  );

  npc_dpath #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_entry_index   (in_tdata[3:0]),
    .in_red           (in_tdata[19:4]),
    .in_green         (in_tdata[35:20]),
    .in_blue          (in_tdata[51:36]),
    .in_clear         (in_tdata[67:52]),
    .out_nearest_index(nearest_index),
    .out_distance     (distance)
  );

  assign out_tdata = {2'b00, distance, nearest_index};

endmodule
